[src/coe_pkg.sv]
// Shared types and constants of the cyclic order closure engine.
// Used by the controller, the datapath and the checker. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package coe_pkg;

    // Result codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_CONFLICT = 2'd1;
    localparam logic [1:0] ST_BAD      = 2'd2;

    // Which oriented triple drives the store read address
    typedef enum logic [2:0] {
        SEL_PORT = 3'd0,   // (a,b,c) straight from the input word
        SEL_ACB  = 3'd1,   // partner of the latched input triple
        SEL_IJK  = 3'd2,
        SEL_IKL  = 3'd3,
        SEL_IJL  = 3'd4,
        SEL_ILJ  = 3'd5
    } t_sel;

    // Loop counter advance request
    typedef enum logic [1:0] {
        ADV_NONE = 2'd0,
        ADV_L    = 2'd1,
        ADV_J    = 2'd2,
        ADV_K    = 2'd3
    } t_adv;

    // Controller to datapath
    typedef struct packed {
        logic clr_we;     // write zero at the clear pointer, then step it
        logic mark_we;    // write one at the address read in the last cycle
        logic latch_in;   // capture the input lines
        logic loop_init;  // i = k = j = 0
        logic l_init;     // l = 0
        t_adv adv;
        t_sel sel;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic rd_bit;     // store bit read in the previous cycle
        logic bad;        // input word has bad operands
        logic k_eq_i;
        logic j_skip;     // j equals i or k
        logic l_skip;     // l equals i, k or j
        logic i_last;
        logic k_last;
        logic j_last;
        logic l_last;
        logic clr_last;
    } t_stat;

endpackage
`default_nettype wire

[src/coe_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module coe_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port (old data on a same-address write)
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[src/coe_datapath.sv]
// Datapath: orientation bit store, loop counters, slot address generation.
// Depends on coe_pkg and coe_ram.
`timescale 1ns / 1ps
`default_nettype none
module coe_datapath #(
    parameter int NUM_LINES = 18
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic [4:0]   i_line_a,
    input  wire logic [4:0]   i_line_b,
    input  wire logic [4:0]   i_line_c,
    input  wire coe_pkg::t_cmd i_cmd,
    output coe_pkg::t_stat    o_stat
);

    localparam int LW    = $clog2(NUM_LINES);
    localparam int DEPTH = NUM_LINES * NUM_LINES * NUM_LINES;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] NL    = AW'(NUM_LINES);
    localparam logic [AW-1:0] NN    = AW'(NUM_LINES * NUM_LINES);
    localparam logic [LW-1:0] LLAST = LW'(NUM_LINES - 1);
    localparam logic [5:0]    NLIM  = 6'(NUM_LINES);

    // Slot of an orientation: the rotation that starts with the smallest line
    function automatic logic [AW-1:0] slot_of(input logic [LW-1:0] a,
                                              input logic [LW-1:0] b,
                                              input logic [LW-1:0] c);
        logic [LW-1:0] x;
        logic [LW-1:0] y;
        logic [LW-1:0] z;
        x = a;
        y = b;
        z = c;
        if (b < a && b < c) begin
            x = b;
            y = c;
            z = a;
        end else if (c < a && c < b) begin
            x = c;
            y = a;
            z = b;
        end
        return AW'(x) * NN + AW'(y) * NL + AW'(z);
    endfunction

    logic [LW-1:0] r_i, r_k, r_j, r_l;
    logic [LW-1:0] n_i, n_k, n_j, n_l;
    logic [LW-1:0] r_a, r_b, r_c;
    logic [AW-1:0] r_clr, n_clr;
    logic [AW-1:0] r_last_addr;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          we;
    logic          rd_bit;
    logic          do_j, do_k, do_i;

    // read address select
    always_comb begin
        case (i_cmd.sel)
            coe_pkg::SEL_PORT: rd_addr = slot_of(i_line_a[LW-1:0], i_line_b[LW-1:0],
                                                 i_line_c[LW-1:0]);
            coe_pkg::SEL_ACB:  rd_addr = slot_of(r_a, r_c, r_b);
            coe_pkg::SEL_IJK:  rd_addr = slot_of(r_i, r_j, r_k);
            coe_pkg::SEL_IKL:  rd_addr = slot_of(r_i, r_k, r_l);
            coe_pkg::SEL_IJL:  rd_addr = slot_of(r_i, r_j, r_l);
            coe_pkg::SEL_ILJ:  rd_addr = slot_of(r_i, r_l, r_j);
            default:           rd_addr = slot_of(r_i, r_j, r_k);
        endcase
    end

    // write: zero during the clear sweep, else one at the last read slot
    assign we      = i_cmd.clr_we | i_cmd.mark_we;
    assign wr_addr = i_cmd.clr_we ? r_clr : r_last_addr;

    coe_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (wr_addr),
        .i_wdata (~i_cmd.clr_we),
        .i_raddr (rd_addr),
        .o_rdata (rd_bit)
    );

    // address of the read in flight
    always_ff @(posedge i_clk) begin
        r_last_addr <= rd_addr;
    end

    // input line capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_a <= i_line_a[LW-1:0];
            r_b <= i_line_b[LW-1:0];
            r_c <= i_line_c[LW-1:0];
        end
    end

    // nested loop counters: l innermost, then j, then k, then i
    always_comb begin
        do_j = (i_cmd.adv == coe_pkg::ADV_J) ||
               ((i_cmd.adv == coe_pkg::ADV_L) && (r_l == LLAST));
        do_k = (i_cmd.adv == coe_pkg::ADV_K) || (do_j && (r_j == LLAST));
        do_i = do_k && (r_k == LLAST);
        n_l  = r_l;
        n_j  = r_j;
        n_k  = r_k;
        n_i  = r_i;
        if (i_cmd.adv == coe_pkg::ADV_L) begin
            n_l = (r_l == LLAST) ? '0 : r_l + 1'b1;
        end
        if (do_j) begin
            n_j = (r_j == LLAST) ? '0 : r_j + 1'b1;
        end
        if (do_k) begin
            n_k = (r_k == LLAST) ? '0 : r_k + 1'b1;
        end
        if (do_i) begin
            n_i = (r_i == LLAST) ? '0 : r_i + 1'b1;
        end
        if (i_cmd.l_init) begin
            n_l = '0;
        end
        if (i_cmd.loop_init) begin
            n_i = '0;
            n_k = '0;
            n_j = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i;
        r_k <= n_k;
        r_j <= n_j;
        r_l <= n_l;
    end

    // clear sweep pointer
    assign n_clr = i_cmd.clr_we ? r_clr + 1'b1 : r_clr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else begin
            r_clr <= n_clr;
        end
    end

    // status back to the controller
    always_comb begin
        o_stat.rd_bit   = rd_bit;
        o_stat.bad      = ({1'b0, i_line_a} >= NLIM) || ({1'b0, i_line_b} >= NLIM) ||
                          ({1'b0, i_line_c} >= NLIM) || (i_line_a == i_line_b) ||
                          (i_line_b == i_line_c) || (i_line_a == i_line_c);
        o_stat.k_eq_i   = (r_k == r_i);
        o_stat.j_skip   = (r_j == r_i) || (r_j == r_k);
        o_stat.l_skip   = (r_l == r_i) || (r_l == r_k) || (r_l == r_j);
        o_stat.i_last   = (r_i == LLAST);
        o_stat.k_last   = (r_k == LLAST);
        o_stat.j_last   = (r_j == LLAST);
        o_stat.l_last   = (r_l == LLAST);
        o_stat.clr_last = (r_clr == AW'(DEPTH - 1));
    end

endmodule
`default_nettype wire

[src/coe_ctrl.sv]
// Controller: sequences clear sweep, set items and the closure pass; owns
// the result register. Depends on coe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module coe_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic          i_kind,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [1:0]         o_status,
    input  wire coe_pkg::t_stat i_stat,
    output coe_pkg::t_cmd      o_cmd
);

    typedef enum logic [10:0] {
        ST_CLEAR    = 11'b000_0000_0001,
        ST_IDLE     = 11'b000_0000_0010,
        ST_SET_CHK  = 11'b000_0000_0100,
        ST_SET_PAR  = 11'b000_0000_1000,
        ST_CL_IJK   = 11'b000_0001_0000,
        ST_CL_IJK_W = 11'b000_0010_0000,
        ST_CL_L     = 11'b000_0100_0000,
        ST_CL_L_W   = 11'b000_1000_0000,
        ST_CL_M1    = 11'b001_0000_0000,
        ST_CL_M2    = 11'b010_0000_0000,
        ST_DONE     = 11'b100_0000_0000
    } t_state;

    t_state     r_state, n_state;
    logic       r_ov, n_ov;
    logic [1:0] r_status, n_status;
    logic [1:0] r_hold, n_hold;
    logic       fin;
    logic [1:0] fin_status;
    logic       accept;
    logic       out_free;
    logic       load;
    logic [1:0] load_val;
    logic       end_k, end_j, end_l;
    logic       step_l;

    assign o_ready  = (r_state == ST_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_ov || i_ready;
    assign end_k    = i_stat.i_last && i_stat.k_last;
    assign end_j    = end_k && i_stat.j_last;
    assign end_l    = end_j && i_stat.l_last;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.adv  = coe_pkg::ADV_NONE;
        o_cmd.sel  = coe_pkg::SEL_PORT;
        fin        = 1'b0;
        fin_status = coe_pkg::ST_OK;
        step_l     = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_we = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_cmd.latch_in = accept;
                o_cmd.loop_init = 1'b1;
                if (accept) begin
                    if (i_kind) begin
                        n_state = ST_CL_IJK;
                    end else if (i_stat.bad) begin
                        fin        = 1'b1;
                        fin_status = coe_pkg::ST_BAD;
                    end else begin
                        n_state = ST_SET_CHK;
                    end
                end
            end
            ST_SET_CHK: begin
                if (i_stat.rd_bit) begin
                    fin = 1'b1;
                end else begin
                    o_cmd.mark_we = 1'b1;
                    o_cmd.sel     = coe_pkg::SEL_ACB;
                    n_state       = ST_SET_PAR;
                end
            end
            ST_SET_PAR: begin
                fin        = 1'b1;
                fin_status = i_stat.rd_bit ? coe_pkg::ST_CONFLICT : coe_pkg::ST_OK;
            end
            ST_CL_IJK: begin
                if (i_stat.k_eq_i) begin
                    o_cmd.adv = coe_pkg::ADV_K;
                    fin       = end_k;
                end else if (i_stat.j_skip) begin
                    o_cmd.adv = coe_pkg::ADV_J;
                    fin       = end_j;
                end else begin
                    o_cmd.sel = coe_pkg::SEL_IJK;
                    n_state   = ST_CL_IJK_W;
                end
            end
            ST_CL_IJK_W: begin
                if (i_stat.rd_bit) begin
                    o_cmd.l_init = 1'b1;
                    n_state      = ST_CL_L;
                end else begin
                    o_cmd.adv = coe_pkg::ADV_J;
                    fin       = end_j;
                    n_state   = ST_CL_IJK;
                end
            end
            ST_CL_L: begin
                if (i_stat.l_skip) begin
                    step_l = 1'b1;
                end else begin
                    o_cmd.sel = coe_pkg::SEL_IKL;
                    n_state   = ST_CL_L_W;
                end
            end
            ST_CL_L_W: begin
                if (i_stat.rd_bit) begin
                    o_cmd.sel = coe_pkg::SEL_IJL;
                    n_state   = ST_CL_M1;
                end else begin
                    step_l = 1'b1;
                end
            end
            ST_CL_M1: begin
                if (i_stat.rd_bit) begin
                    step_l = 1'b1;
                end else begin
                    o_cmd.mark_we = 1'b1;
                    o_cmd.sel     = coe_pkg::SEL_ILJ;
                    n_state       = ST_CL_M2;
                end
            end
            ST_CL_M2: begin
                if (i_stat.rd_bit) begin
                    fin        = 1'b1;
                    fin_status = coe_pkg::ST_CONFLICT;
                end else begin
                    step_l = 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // advance the inner loop; back to j when l wraps
        if (step_l) begin
            o_cmd.adv = coe_pkg::ADV_L;
            fin       = end_l;
            n_state   = i_stat.l_last ? ST_CL_IJK : ST_CL_L;
        end

        if (fin) begin
            n_state = out_free ? ST_IDLE : ST_DONE;
        end
    end

    // result register; a finished word waits in r_hold while the slot is full
    always_comb begin
        load     = (fin && out_free) || ((r_state == ST_DONE) && out_free);
        load_val = fin ? fin_status : r_hold;
        n_hold   = fin ? fin_status : r_hold;
        n_ov     = (r_ov && !i_ready) || load;
        n_status = load ? load_val : r_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_hold   <= n_hold;
    end

    assign o_valid  = r_ov;
    assign o_status = r_status;

endmodule
`default_nettype wire

[src/cyclic_order_closure_engine.sv]
// Cyclic order closure engine: one bit per cyclic orientation of each
// triple of distinct lines, kept in a NUM_LINES^3 x 1 RAM. After reset the
// block sweeps all NUM_LINES^3 entries to zero, one entry per cycle, and
// takes no word until the sweep ends. A set word with bad operands ends with
// ST_BAD; else it reads its slot and, if clear, marks it and reads the partner
// orientation, bound by the single read port with registered data. A close
// word runs the four nested loops over unskipped indices: it reads (i,j,k),
// if set each (i,k,l), if set (i,j,l), marks (i,j,l) if clear and then reads
// (i,l,j) for a conflict. One word is worked on at a time; a finished result
// sits in the output register while the next word enters.
// Depends on coe_pkg, coe_ctrl, coe_datapath and coe_ram.
`timescale 1ns / 1ps
`default_nettype none
module cyclic_order_closure_engine #(
    parameter int NUM_LINES = 18
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic       i_kind,
    input  wire logic [4:0] i_line_a,
    input  wire logic [4:0] i_line_b,
    input  wire logic [4:0] i_line_c,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [1:0]      o_status
);

    coe_pkg::t_cmd  cmd;
    coe_pkg::t_stat stat;

    coe_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_kind   (i_kind),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_status (o_status),
        .i_stat   (stat),
        .o_cmd    (cmd)
    );

    coe_datapath #(
        .NUM_LINES (NUM_LINES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_line_a (i_line_a),
        .i_line_b (i_line_b),
        .i_line_c (i_line_c),
        .i_cmd    (cmd),
        .o_stat   (stat)
    );

endmodule
`default_nettype wire

[src/coe_checker.sv]
// Port-level checks for the cyclic order closure engine, bound to the top.
// Depends on coe_pkg and cyclic_order_closure_engine.
`timescale 1ns / 1ps
`default_nettype none
module coe_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_ready,
    input wire logic       i_kind,
    input wire logic [4:0] i_line_a,
    input wire logic [4:0] i_line_b,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [1:0] o_status
);

    // no result straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result word valid after reset");

    // a waiting result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status))
        else $error("result word changed while stalled");

    // only defined codes leave the block
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == coe_pkg::ST_OK) || (o_status == coe_pkg::ST_CONFLICT) ||
                    (o_status == coe_pkg::ST_BAD))
        else $error("undefined status code");

    // a close pass never finishes in the cycle it is taken
    a_close_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_kind |=> !o_ready)
        else $error("input ready right after a close word");

    // repeated line on a set word reports bad operands at once
    a_bad_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && !i_kind && (i_line_a == i_line_b) && !o_valid
        |=> o_valid && (o_status == coe_pkg::ST_BAD))
        else $error("bad operands not reported");

endmodule

bind cyclic_order_closure_engine coe_checker u_coe_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_ready  (o_ready),
    .i_kind   (i_kind),
    .i_line_a (i_line_a),
    .i_line_b (i_line_b),
    .o_valid  (o_valid),
    .i_ready  (i_ready),
    .o_status (o_status)
);
`default_nettype wire
